[design/slc_pkg.sv]
// Shared types and constants of the set-associative LRU byte cache.
package slc_pkg;

  localparam int ADDR_BITS         = 16;
  localparam int STAMP_W           = 32;
  localparam int WAYS_DEF          = 4;
  localparam int TOTAL_LINES_DEF   = 64;
  localparam int LINE_BYTES_DEF    = 16;

  localparam logic KIND_READ  = 1'b0;
  localparam logic KIND_WRITE = 1'b1;

  typedef struct packed {
    logic                 kind;
    logic [ADDR_BITS-1:0] byte_address;
    logic [7:0]           write_data;
  } in_item_t;

  typedef struct packed {
    logic                 hit;
    logic [7:0]           read_data;
    logic                 evicted_dirty;
    logic [ADDR_BITS-1:0] evicted_line_address;
  } out_item_t;

endpackage

[design/slc_ram.sv]
// Simple dual-port synchronous RAM with one write port and a registered read port.
module slc_ram #(
  parameter int DW = 8,
  parameter int AW = 4
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/set_assoc_lru_byte_cache_core.sv]
// Top level of the set-associative LRU byte cache with its backing byte store.
//
//   channel | direction | handshake          | payload
//   in_     | input     | in_valid/in_stall   | in_data (in_item_t)
//   out_    | output    | out_valid/out_stall | out_data (out_item_t)
//   cfg_    | input     | cfg_valid/cfg_ready | cfg_data (write_back_mode)
//
// On a lookup the ways are read one at a time from the tag memory. A miss adds a victim step
// and a line fill, with a dirty victim written back to the backing store first; a write-through
// store also copies the whole line out. Line moves are limited by one byte per cycle through
// the RAM ports. After reset the backing store is cleared with in_stall high.
// One item is in work at a time; a finished result waits in the output register.
module set_assoc_lru_byte_cache_core #(
  parameter int WAYS        = slc_pkg::WAYS_DEF,
  parameter int TOTAL_LINES = slc_pkg::TOTAL_LINES_DEF,
  parameter int LINE_BYTES  = slc_pkg::LINE_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  slc_pkg::in_item_t in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output slc_pkg::out_item_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_data
);
  import slc_pkg::*;

  localparam int OB       = $clog2(LINE_BYTES + 1) - 1;
  localparam int LBP2     = 1 << OB;
  localparam int SETS_RAW = TOTAL_LINES / WAYS;
  localparam int SETS_R1  = (SETS_RAW > 0) ? SETS_RAW : 1;
  localparam int SB       = $clog2(SETS_R1 + 1) - 1;
  localparam int SETS     = 1 << SB;
  localparam int NW       = (WAYS * SETS <= TOTAL_LINES) ? WAYS : TOTAL_LINES;
  localparam int SLOT_W   = (TOTAL_LINES > 1) ? $clog2(TOTAL_LINES) : 1;
  localparam int WAY_W    = (NW > 1) ? $clog2(NW) : 1;
  localparam int SET_W    = (SB > 0) ? SB : 1;
  localparam int OFF_W    = (OB > 0) ? OB : 1;
  localparam int TAG_RAW  = ADDR_BITS - OB - SB;
  localparam int TAG_W    = (TAG_RAW > 0) ? TAG_RAW : 1;
  localparam int LADDR_W  = ((TOTAL_LINES * LBP2) > 1) ? $clog2(TOTAL_LINES * LBP2) : 1;
  localparam int CNT_W    = OB + 1;
  localparam int META_W   = TAG_W + 1 + STAMP_W;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_RD, S_CMP, S_MISS, S_WB, S_FILL, S_UPD, S_RDATA, S_WT, S_DONE
  } state_t;

  state_t                 state_r, state_nxt;
  in_item_t               req_r, req_nxt;
  logic [WAY_W-1:0]       way_r, way_nxt;
  logic [SLOT_W-1:0]      slot_r, slot_nxt;
  logic [SLOT_W-1:0]      vic_slot_r, vic_slot_nxt;
  logic                   vic_valid_r, vic_valid_nxt;
  logic                   vic_dirty_r, vic_dirty_nxt;
  logic [TAG_W-1:0]       vic_tag_r, vic_tag_nxt;
  logic [STAMP_W-1:0]     vic_stamp_r, vic_stamp_nxt;
  logic                   hit_r, hit_nxt;
  logic                   hit_dirty_r, hit_dirty_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [ADDR_BITS-1:0]   clr_r, clr_nxt;
  logic [TOTAL_LINES-1:0] valid_r, valid_nxt;
  logic [STAMP_W-1:0]     acc_r, acc_nxt;
  logic                   mode_r, mode_nxt;
  logic                   evict_r, evict_nxt;
  logic [ADDR_BITS-1:0]   evict_addr_r, evict_addr_nxt;
  logic [7:0]             rdata_r, rdata_nxt;
  logic                   out_valid_r, out_valid_nxt;
  out_item_t              out_r, out_nxt;

  logic [OFF_W-1:0]       off;
  logic [SET_W-1:0]       set_idx;
  logic [TAG_W-1:0]       tag;
  logic [ADDR_BITS-1:0]   line_base;
  logic [SLOT_W-1:0]      cur_slot;
  logic [OFF_W-1:0]       cnt_idx, cnt_prev_idx;

  logic                   meta_we;
  logic [SLOT_W-1:0]      meta_raddr;
  logic [META_W-1:0]      meta_wdata, meta_q;
  logic [TAG_W-1:0]       m_tag;
  logic                   m_dirty, m_valid, take;
  logic [STAMP_W-1:0]     m_stamp;

  logic                   line_we;
  logic [LADDR_W-1:0]     line_waddr, line_raddr;
  logic [7:0]             line_wdata, line_q;

  logic                   bk_we;
  logic [ADDR_BITS-1:0]   bk_waddr, bk_raddr;
  logic [7:0]             bk_wdata, bk_q;

  logic                   dirty_final;

  function automatic logic [LADDR_W-1:0] laddr(logic [SLOT_W-1:0] s, logic [OFF_W-1:0] o);
    logic [31:0] a;
    a = (32'(s) << OB) | (32'(o) & 32'(LBP2 - 1));
    return LADDR_W'(a);
  endfunction

  assign off       = OFF_W'(req_r.byte_address & ADDR_BITS'(LBP2 - 1));
  assign set_idx   = SET_W'((req_r.byte_address >> OB) & ADDR_BITS'(SETS - 1));
  assign tag       = TAG_W'(req_r.byte_address >> (OB + SB));
  assign line_base = req_r.byte_address & ~ADDR_BITS'(LBP2 - 1);
  assign cur_slot  = SLOT_W'((32'(way_r) << SB) | (32'(set_idx) & 32'(SETS - 1)));
  assign cnt_idx      = OFF_W'(cnt_r);
  assign cnt_prev_idx = OFF_W'(cnt_r - CNT_W'(1));

  assign m_stamp = meta_q[STAMP_W-1:0];
  assign m_dirty = meta_q[STAMP_W];
  assign m_tag   = meta_q[META_W-1 -: TAG_W];
  assign m_valid = valid_r[cur_slot];
  assign take    = (way_r == '0) || (vic_valid_r && (!m_valid || (m_stamp < vic_stamp_r)));
  assign dirty_final = (hit_r & hit_dirty_r) | ((req_r.kind == KIND_WRITE) & mode_r);

  assign meta_raddr = cur_slot;
  assign meta_wdata = {tag, dirty_final, acc_r};

  slc_ram #(.DW(META_W), .AW(SLOT_W)) u_meta (
    .clk(clk), .we(meta_we), .waddr(slot_r), .wdata(meta_wdata),
    .raddr(meta_raddr), .rdata(meta_q)
  );

  slc_ram #(.DW(8), .AW(LADDR_W)) u_line (
    .clk(clk), .we(line_we), .waddr(line_waddr), .wdata(line_wdata),
    .raddr(line_raddr), .rdata(line_q)
  );

  slc_ram #(.DW(8), .AW(ADDR_BITS)) u_back (
    .clk(clk), .we(bk_we), .waddr(bk_waddr), .wdata(bk_wdata),
    .raddr(bk_raddr), .rdata(bk_q)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign cfg_ready = 1'b1;

  always_comb begin
    state_nxt      = state_r;
    req_nxt        = req_r;
    way_nxt        = way_r;
    slot_nxt       = slot_r;
    vic_slot_nxt   = vic_slot_r;
    vic_valid_nxt  = vic_valid_r;
    vic_dirty_nxt  = vic_dirty_r;
    vic_tag_nxt    = vic_tag_r;
    vic_stamp_nxt  = vic_stamp_r;
    hit_nxt        = hit_r;
    hit_dirty_nxt  = hit_dirty_r;
    cnt_nxt        = cnt_r;
    clr_nxt        = clr_r;
    valid_nxt      = valid_r;
    acc_nxt        = acc_r;
    mode_nxt       = (cfg_valid && cfg_ready) ? cfg_data : mode_r;
    evict_nxt      = evict_r;
    evict_addr_nxt = evict_addr_r;
    rdata_nxt      = rdata_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_nxt        = out_r;

    meta_we    = 1'b0;
    line_we    = 1'b0;
    line_waddr = laddr(slot_r, cnt_prev_idx);
    line_wdata = bk_q;
    line_raddr = laddr(slot_r, cnt_idx);
    bk_we      = 1'b0;
    bk_waddr   = evict_addr_r + ADDR_BITS'(cnt_prev_idx);
    bk_wdata   = line_q;
    bk_raddr   = line_base + ADDR_BITS'(cnt_idx);

    unique case (state_r)
      S_CLR: begin
        bk_we    = 1'b1;
        bk_waddr = clr_r;
        bk_wdata = 8'd0;
        clr_nxt  = clr_r + ADDR_BITS'(1);
        if (&clr_r) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          req_nxt        = in_data;
          way_nxt        = '0;
          hit_nxt        = 1'b0;
          evict_nxt      = 1'b0;
          evict_addr_nxt = '0;
          rdata_nxt      = 8'd0;
          state_nxt      = S_RD;
        end
      end
      S_RD: begin
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (m_valid && (m_tag == tag)) begin
          hit_nxt       = 1'b1;
          hit_dirty_nxt = m_dirty;
          slot_nxt      = cur_slot;
          state_nxt     = S_UPD;
        end else begin
          if (take) begin
            vic_slot_nxt  = cur_slot;
            vic_valid_nxt = m_valid;
            vic_dirty_nxt = m_dirty;
            vic_tag_nxt   = m_tag;
            vic_stamp_nxt = m_stamp;
          end
          if (32'(way_r) == NW - 1) begin
            state_nxt = S_MISS;
          end else begin
            way_nxt   = way_r + WAY_W'(1);
            state_nxt = S_RD;
          end
        end
      end
      S_MISS: begin
        slot_nxt = vic_slot_r;
        cnt_nxt  = '0;
        if (vic_valid_r && vic_dirty_r) begin
          evict_nxt      = 1'b1;
          evict_addr_nxt = ADDR_BITS'((32'(vic_tag_r) << (OB + SB)) |
                                      ((32'(set_idx) & 32'(SETS - 1)) << OB));
          state_nxt      = S_WB;
        end else begin
          state_nxt = S_FILL;
        end
      end
      S_WB: begin
        // The line byte read at cnt is registered by the RAM and goes to the backing store in the next cycle.
        bk_we = (cnt_r != '0);
        if (cnt_r == CNT_W'(LBP2)) begin
          cnt_nxt   = '0;
          state_nxt = S_FILL;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      S_FILL: begin
        line_we = (cnt_r != '0);
        if (cnt_r == CNT_W'(LBP2)) begin
          cnt_nxt   = '0;
          state_nxt = S_UPD;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      S_UPD: begin
        meta_we            = 1'b1;
        valid_nxt[slot_r]  = 1'b1;
        acc_nxt            = acc_r + STAMP_W'(1);
        if (req_r.kind == KIND_WRITE) begin
          line_we    = 1'b1;
          line_waddr = laddr(slot_r, off);
          line_wdata = req_r.write_data;
          cnt_nxt    = '0;
          state_nxt  = mode_r ? S_DONE : S_WT;
        end else begin
          line_raddr = laddr(slot_r, off);
          state_nxt  = S_RDATA;
        end
      end
      S_RDATA: begin
        rdata_nxt = line_q;
        state_nxt = S_DONE;
      end
      S_WT: begin
        bk_we    = (cnt_r != '0);
        bk_waddr = line_base + ADDR_BITS'(cnt_prev_idx);
        if (cnt_r == CNT_W'(LBP2)) begin
          state_nxt = S_DONE;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt                = 1'b1;
          out_nxt.hit                  = hit_r;
          out_nxt.read_data            = rdata_r;
          out_nxt.evicted_dirty        = evict_r;
          out_nxt.evicted_line_address = evict_addr_r;
          state_nxt                    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      valid_r     <= '0;
      acc_r       <= STAMP_W'(1);
      mode_r      <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      valid_r     <= valid_nxt;
      acc_r       <= acc_nxt;
      mode_r      <= mode_nxt;
      out_valid_r <= out_valid_nxt;
    end
    req_r        <= req_nxt;
    way_r        <= way_nxt;
    slot_r       <= slot_nxt;
    vic_slot_r   <= vic_slot_nxt;
    vic_valid_r  <= vic_valid_nxt;
    vic_dirty_r  <= vic_dirty_nxt;
    vic_tag_r    <= vic_tag_nxt;
    vic_stamp_r  <= vic_stamp_nxt;
    hit_r        <= hit_nxt;
    hit_dirty_r  <= hit_dirty_nxt;
    cnt_r        <= cnt_nxt;
    evict_r      <= evict_nxt;
    evict_addr_r <= evict_addr_nxt;
    rdata_r      <= rdata_nxt;
    out_r        <= out_nxt;
  end

  // A hit never evicts a line.
  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_r.hit && out_r.evicted_dirty))
    else $error("hit reported together with an eviction");

  // The eviction address is zero unless a dirty line was written back.
  a_evict_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.evicted_dirty) |-> (out_r.evicted_line_address == '0))
    else $error("eviction address without eviction");

  // An accepted transfer always starts a tag lookup.
  a_accept_lookup: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == S_RD))
    else $error("accepted transfer did not start a lookup");

  // Each access advances the use counter exactly once.
  a_stamp_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UPD) |=> (acc_r == $past(acc_r) + STAMP_W'(1)))
    else $error("use counter did not advance");

endmodule

[tb/testbench.sv]
// Self-checking testbench of the set-associative LRU byte cache core.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import slc_pkg::*;

  localparam int WAYS = WAYS_DEF;
  localparam int LINES = TOTAL_LINES_DEF;
  localparam int LBYTES = LINE_BYTES_DEF;
  localparam int OB = $clog2(LBYTES);
  localparam int SETS = LINES / WAYS;
  localparam int SB = $clog2(SETS);
  localparam int TAG_W = ADDR_BITS - OB - SB;
  localparam longint CYCLE_LIMIT = 3000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_data = 1'b0;

  set_assoc_lru_byte_cache_core DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Cache mirror.
  logic              wb_mode;
  logic [TAG_W-1:0]  tag_q [LINES];
  logic              valid_q [LINES];
  logic              dirty_q [LINES];
  logic [31:0]       stamp_q [LINES];
  logic [31:0]       access_count;
  logic [7:0]        line_data [LINES][LBYTES];
  logic [7:0]        backing [2**ADDR_BITS];

  out_item_t expected_q[$];
  int  errors = 0;
  longint cycles = 0;
  int  hold_cycles = 0;
  bit  random_stall = 1'b0;

  task automatic write_line_out(int slot, logic [ADDR_BITS-1:0] base);
    for (int i = 0; i < LBYTES; i++) backing[base + i] = line_data[slot][i];
  endtask

  task automatic predict_access(in_item_t it);
    out_item_t r;
    logic [OB-1:0] offset;
    int set_idx, slot, s;
    logic [TAG_W-1:0] tg;
    logic [ADDR_BITS-1:0] base;
    bit found;
    r = '0;
    offset = it.byte_address[OB-1:0];
    set_idx = int'(it.byte_address[OB +: SB]);
    tg = it.byte_address[ADDR_BITS-1 -: TAG_W];
    base = {it.byte_address[ADDR_BITS-1:OB], {OB{1'b0}}};
    slot = 0;
    found = 1'b0;
    for (int w = 0; w < WAYS; w++) begin
      s = w * SETS + set_idx;
      if (!found && valid_q[s] && tag_q[s] == tg) begin
        found = 1'b1;
        slot = s;
      end
    end
    r.hit = found;
    if (!found) begin
      slot = set_idx;
      for (int w = 1; w < WAYS; w++) begin
        s = w * SETS + set_idx;
        if (valid_q[slot] && (!valid_q[s] || stamp_q[s] < stamp_q[slot])) slot = s;
      end
      if (valid_q[slot] && dirty_q[slot]) begin
        r.evicted_dirty = 1'b1;
        r.evicted_line_address = {tag_q[slot], set_idx[SB-1:0], {OB{1'b0}}};
        write_line_out(slot, r.evicted_line_address);
      end
      dirty_q[slot] = 1'b0;
      for (int i = 0; i < LBYTES; i++) line_data[slot][i] = backing[base + i];
      tag_q[slot] = tg;
      valid_q[slot] = 1'b1;
    end
    stamp_q[slot] = access_count;
    access_count++;
    if (it.kind == KIND_WRITE) begin
      line_data[slot][offset] = it.write_data;
      if (wb_mode) dirty_q[slot] = 1'b1;
      else write_line_out(slot, base);
    end else begin
      r.read_data = line_data[slot][offset];
    end
    expected_q.push_back(r);
  endtask

  // in_valid stays high into the next item when no gap is drawn; a gap or a drain drops it.
  task automatic send_access(logic kind, logic [ADDR_BITS-1:0] addr, logic [7:0] wd,
                             bit gaps = 1'b1);
    in_item_t it;
    int gap;
    it.kind = kind;
    it.byte_address = addr;
    it.write_data = wd;
    gap = gaps ? $urandom_range(0, 11) : 0;
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_access(it);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic set_write_back(logic mode);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data <= mode;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    wb_mode = mode;
  endtask

  // Result checking and receiver stalls.
  always @(posedge clk) begin
    out_item_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_data);
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (out_data.hit !== e.hit)
          $display("%0t: hit expected %0d actual %0d", $time, e.hit, out_data.hit);
        if (out_data.read_data !== e.read_data)
          $display("%0t: read_data expected %h actual %h", $time, e.read_data,
                   out_data.read_data);
        if (out_data.evicted_dirty !== e.evicted_dirty)
          $display("%0t: evicted_dirty expected %0d actual %0d", $time,
                   e.evicted_dirty, out_data.evicted_dirty);
        if (out_data.evicted_line_address !== e.evicted_line_address)
          $display("%0t: evicted_line_address expected %h actual %h", $time,
                   e.evicted_line_address, out_data.evicted_line_address);
        if (out_data !== e) errors++;
      end
    end
  end

  int stall_left = 0;
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall <= 1'b1;
    end else if (!random_stall) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if (out_valid && !out_stall) begin
      stall_left <= $urandom_range(0, 11);
      out_stall <= 1'b0;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("set_assoc_lru_byte_cache_core: mismatch");
      $finish;
    end
  end

  task automatic test_directed();
    send_access(KIND_READ, 16'h0000, 8'h00);
    send_access(KIND_WRITE, 16'h0005, 8'hFF);
    send_access(KIND_READ, 16'h0005, 8'h00);
    send_access(KIND_WRITE, 16'hFFFF, 8'hA5);
    send_access(KIND_READ, 16'hFFFF, 8'h00);
    // Five tags into set zero: the last two each evict the dirty least recent line.
    for (int t = 1; t <= 5; t++)
      send_access(KIND_WRITE, 16'(t << (OB + SB)), 8'(t * 17));
    send_access(KIND_READ, 16'h0005, 8'h00);
    send_access(KIND_READ, 16'(1 << (OB + SB)), 8'h00);
  endtask

  task automatic test_write_through();
    set_write_back(1'b0);
    send_access(KIND_WRITE, 16'h0005, 8'h3C);
    send_access(KIND_WRITE, 16'h1230, 8'h5A);
    for (int t = 8; t < 13; t++)
      send_access(KIND_READ, 16'(t << (OB + SB)), 8'h00);
    send_access(KIND_READ, 16'h1230, 8'h00);
    set_write_back(1'b1);
  endtask

  // Addresses mostly from a small pool of tags so that hits and evictions both occur.
  function automatic logic [ADDR_BITS-1:0] pick_address();
    if ($urandom_range(0, 4) == 0) return 16'($urandom);
    return {6'($urandom_range(0, 5)), 4'($urandom_range(0, 1) * 15), 2'($urandom),
            4'($urandom)};
  endfunction

  task automatic test_random(int n, logic mode);
    set_write_back(mode);
    random_stall = 1'b1;
    for (int i = 0; i < n; i++)
      send_access(logic'($urandom_range(0, 1)), pick_address(), 8'($urandom));
    random_stall = 1'b0;
  endtask

  task automatic test_backpressure();
    hold_cycles = 400;
    for (int i = 0; i < 12; i++)
      send_access(logic'($urandom_range(0, 1)), pick_address(), 8'($urandom), 1'b0);
  endtask

  initial begin
    wb_mode = 1'b1;
    access_count = 32'd1;
    for (int i = 0; i < LINES; i++) begin
      tag_q[i] = '0; valid_q[i] = 1'b0; dirty_q[i] = 1'b0; stamp_q[i] = '0;
    end
    for (int i = 0; i < 2**ADDR_BITS; i++) backing[i] = 8'h00;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_write_through();
    test_random(200, 1'b1);
    test_backpressure();
    test_random(150, 1'b0);
    test_random(80, 1'b1);
    drain_results();
    if (errors == 0 && expected_q.size() == 0) begin
      $display("set_assoc_lru_byte_cache_core: match");
    end else begin
      $display("set_assoc_lru_byte_cache_core: mismatch");
    end
    $finish;
  end
endmodule

[filelist.f]
design/slc_pkg.sv
design/slc_ram.sv
design/set_assoc_lru_byte_cache_core.sv
tb/testbench.sv
